// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the fader RTL.
// Assertions sample on clk_i and are disabled while rst_ni is low.
// Define SYNTH to drop them from a synthesis build.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge out of reset.
`define ASSERT_ON(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition must never be seen at a clock edge out of reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_ON(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif

`endif

// ===== rtl/lbf_pkg.sv =====
// Package for the linear brightness fader: widths, reset constants, codes,
// sequencer states and divider request/response structs. No dependencies.
package lbf_pkg;

  localparam int LEVEL_W = 8;
  localparam int TIME_W  = 32;
  localparam int CFG_W   = 16;
  localparam int PROD_W  = LEVEL_W + TIME_W;
  localparam int QUO_W   = LEVEL_W;
  localparam int CNT_W   = $clog2(QUO_W);

  localparam logic [LEVEL_W-1:0] DEFAULT_LEVEL      = 8'd128;
  localparam logic [LEVEL_W-1:0] TARGET_RESET_LEVEL = 8'd50;
  localparam logic [CFG_W-1:0]   CANCEL_RESET_MS    = 16'd300;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_START  = 2'd1,
    ACT_CANCEL = 2'd2,
    ACT_SET    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_WB
  } state_e;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [TIME_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/lbf_in_if.sv =====
// Input channel of the fader: valid/ready handshake with the item payload.
// Depends on nothing.
interface lbf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] now_ms;
  logic [7:0]  from_level;
  logic [7:0]  to_level;
  logic [31:0] duration_ms;

  modport source (output valid, action, now_ms, from_level, to_level, duration_ms,
                  input ready);
  modport sink   (input valid, action, now_ms, from_level, to_level, duration_ms,
                  output ready);
endinterface

// ===== rtl/lbf_out_if.sv =====
// Result channel of the fader: valid/ready handshake with level and fading.
// Depends on nothing.
interface lbf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] level;
  logic       fading;

  modport source (output valid, level, fading, input ready);
  modport sink   (input valid, level, fading, output ready);
endinterface

// ===== rtl/lbf_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on lbf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lbf_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lbf_pkg::div_req_t   req_i,
  output lbf_pkg::div_rsp_t   rsp_o
);

  // Caller guarantees quotient < 2^QUO_W, so the high part of the dividend
  // is already a valid partial remainder.
  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [lbf_pkg::CNT_W-1:0]         cnt_q, cnt_d;
  logic [lbf_pkg::TIME_W-1:0]        rem_q, rem_d;
  logic [lbf_pkg::QUO_W-1:0]         lo_q, lo_d;
  logic [lbf_pkg::QUO_W-1:0]         quo_q, quo_d;
  logic [lbf_pkg::TIME_W-1:0]        dvs_q, dvs_d;
  logic [lbf_pkg::TIME_W:0]          trial;
  logic [lbf_pkg::TIME_W:0]          diff;
  logic                              fits;

  assign trial = {rem_q, lo_q[lbf_pkg::QUO_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    lo_d   = lo_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = lbf_pkg::CNT_W'(lbf_pkg::QUO_W - 1);
      rem_d  = req_i.dividend[lbf_pkg::PROD_W-1:lbf_pkg::QUO_W];
      lo_d   = req_i.dividend[lbf_pkg::QUO_W-1:0];
      quo_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? diff[lbf_pkg::TIME_W-1:0] : trial[lbf_pkg::TIME_W-1:0];
      lo_d  = {lo_q[lbf_pkg::QUO_W-2:0], 1'b0};
      quo_d = {quo_q[lbf_pkg::QUO_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  `ASSERT_ON(a_div_no_overflow, req_i.start |-> (req_i.dividend[lbf_pkg::PROD_W-1:lbf_pkg::QUO_W] < req_i.divisor), "divider start would overflow quotient")
  `ASSERT_NEVER(a_div_start_busy, req_i.start && busy_q, "divider restarted while busy")
  `ASSERT_ON(a_div_done_pulse, done_q |=> !done_q, "divider done longer than one cycle")

endmodule

// ===== rtl/linear_brightness_fader.sv =====
// Linear brightness fader, top level: action decode, fade state, sequencer
// and result register. Depends on lbf_pkg, lbf_in_if, lbf_out_if, lbf_div.
//
// Backlight fade engine. Each input transfer carries an action (tick, start
// fade, cancel fade, set level) and the current millisecond time; each one
// produces exactly one result transfer with the level driven and whether a
// fade is still running. Start, cancel, set, a tick while idle and a tick
// that ends a fade complete in the accept cycle, so such items can follow
// back to back as long as the result side keeps taking transfers. A tick in
// the middle of a fade computes from + (to - from) * elapsed / duration:
// the multiply state forms the 8x32 product, then the restoring divider
// works out the 8-bit quotient one bit per cycle, then the write-back state
// loads the result once the output register is free; only then is the next
// input accepted. Input ready is low while a tick is being worked on and
// while a finished result still sits in the output register unclaimed.
// cancel_fade_ms is written through cfg_we_i/cfg_wdata_i; write it only
// while the block is idle.
`include "assert_macros.svh"

module linear_brightness_fader (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lbf_pkg::CFG_W-1:0]   cfg_wdata_i,
  lbf_in_if.sink                      in_i,
  lbf_out_if.source                   res_o
);

  lbf_pkg::state_e state_q, state_d;

  // fade state
  logic [lbf_pkg::LEVEL_W-1:0] start_lvl_q, start_lvl_d;
  logic [lbf_pkg::LEVEL_W-1:0] tgt_lvl_q, tgt_lvl_d;
  logic [lbf_pkg::TIME_W-1:0]  start_time_q, start_time_d;
  logic [lbf_pkg::TIME_W-1:0]  len_q, len_d;
  logic                        active_q, active_d;
  logic [lbf_pkg::LEVEL_W-1:0] cur_lvl_q, cur_lvl_d;
  logic [lbf_pkg::CFG_W-1:0]   cancel_q, cancel_d;
  logic [lbf_pkg::TIME_W-1:0]  elapsed_q, elapsed_d;

  // result register
  logic                        out_vld_q, out_vld_d;
  logic [lbf_pkg::LEVEL_W-1:0] out_lvl_q, out_lvl_d;
  logic                        out_fad_q, out_fad_d;

  logic                        accept;
  logic                        out_free;
  lbf_pkg::action_e            action;
  logic [lbf_pkg::TIME_W-1:0]  elapsed_now;
  logic                        tick_div;
  logic                        fade_up;
  logic [lbf_pkg::LEVEL_W-1:0] span;
  logic [lbf_pkg::PROD_W-1:0]  prod;
  logic [lbf_pkg::LEVEL_W-1:0] wb_lvl;

  lbf_pkg::div_req_t div_req;
  lbf_pkg::div_rsp_t div_rsp;

  assign out_free   = !out_vld_q || res_o.ready;
  assign in_i.ready = (state_q == lbf_pkg::ST_IDLE) && out_free;
  assign accept     = in_i.valid && in_i.ready;
  assign action     = lbf_pkg::action_e'(in_i.action);

  // modular elapsed time
  assign elapsed_now = in_i.now_ms - start_time_q;
  // tick that needs the multiply/divide path
  assign tick_div = (action == lbf_pkg::ACT_TICK) && active_q && (elapsed_now < len_q);

  assign fade_up = tgt_lvl_q >= start_lvl_q;
  assign span    = fade_up ? (tgt_lvl_q - start_lvl_q) : (start_lvl_q - tgt_lvl_q);
  assign prod    = lbf_pkg::PROD_W'(span) * lbf_pkg::PROD_W'(elapsed_q);

  // span * elapsed < span * len, so the quotient always fits in a level
  assign div_req.start    = (state_q == lbf_pkg::ST_MUL);
  assign div_req.dividend = prod;
  assign div_req.divisor  = len_q;

  assign wb_lvl = fade_up ? (start_lvl_q + div_rsp.quotient)
                          : (start_lvl_q - div_rsp.quotient);

  lbf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lbf_pkg::ST_IDLE: begin
        if (accept && tick_div) state_d = lbf_pkg::ST_MUL;
      end
      lbf_pkg::ST_MUL: begin
        state_d = lbf_pkg::ST_DIV;
      end
      lbf_pkg::ST_DIV: begin
        if (div_rsp.done) state_d = lbf_pkg::ST_WB;
      end
      lbf_pkg::ST_WB: begin
        if (out_free) state_d = lbf_pkg::ST_IDLE;
      end
      default: state_d = lbf_pkg::ST_IDLE;
    endcase
  end

  // fade state and result register updates
  always_comb begin
    start_lvl_d  = start_lvl_q;
    tgt_lvl_d    = tgt_lvl_q;
    start_time_d = start_time_q;
    len_d        = len_q;
    active_d     = active_q;
    cur_lvl_d    = cur_lvl_q;
    elapsed_d    = elapsed_q;
    cancel_d     = cfg_we_i ? cfg_wdata_i : cancel_q;
    out_vld_d    = out_vld_q && !res_o.ready;
    out_lvl_d    = out_lvl_q;
    out_fad_d    = out_fad_q;

    if ((state_q == lbf_pkg::ST_IDLE) && accept) begin
      case (action)
        lbf_pkg::ACT_TICK: begin
          if (active_q) begin
            if (tick_div) begin
              elapsed_d = elapsed_now;
            end else begin
              // fade ran its course (also covers zero duration)
              cur_lvl_d = tgt_lvl_q;
              active_d  = 1'b0;
            end
          end
        end
        lbf_pkg::ACT_START: begin
          start_lvl_d  = in_i.from_level;
          tgt_lvl_d    = in_i.to_level;
          start_time_d = in_i.now_ms;
          len_d        = in_i.duration_ms;
          active_d     = 1'b1;
          cur_lvl_d    = in_i.from_level;
        end
        lbf_pkg::ACT_CANCEL: begin
          // fade from whatever is driven now
          start_lvl_d  = cur_lvl_q;
          tgt_lvl_d    = in_i.to_level;
          start_time_d = in_i.now_ms;
          len_d        = lbf_pkg::TIME_W'(cancel_q);
          active_d     = 1'b1;
        end
        lbf_pkg::ACT_SET: begin
          cur_lvl_d = in_i.from_level;
        end
        default: begin
          cur_lvl_d = cur_lvl_q;
        end
      endcase
      if (!tick_div) begin
        out_vld_d = 1'b1;
        out_lvl_d = cur_lvl_d;
        out_fad_d = active_d;
      end
    end else if ((state_q == lbf_pkg::ST_WB) && out_free) begin
      cur_lvl_d = wb_lvl;
      out_vld_d = 1'b1;
      out_lvl_d = wb_lvl;
      out_fad_d = active_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lbf_pkg::ST_IDLE;
      start_lvl_q  <= '0;
      tgt_lvl_q    <= lbf_pkg::TARGET_RESET_LEVEL;
      start_time_q <= '0;
      len_q        <= '0;
      active_q     <= 1'b0;
      cur_lvl_q    <= lbf_pkg::DEFAULT_LEVEL;
      cancel_q     <= lbf_pkg::CANCEL_RESET_MS;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      start_lvl_q  <= start_lvl_d;
      tgt_lvl_q    <= tgt_lvl_d;
      start_time_q <= start_time_d;
      len_q        <= len_d;
      active_q     <= active_d;
      cur_lvl_q    <= cur_lvl_d;
      cancel_q     <= cancel_d;
      out_vld_q    <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    elapsed_q <= elapsed_d;
    out_lvl_q <= out_lvl_d;
    out_fad_q <= out_fad_d;
  end

  assign res_o.valid  = out_vld_q;
  assign res_o.level  = out_lvl_q;
  assign res_o.fading = out_fad_q;

  `ASSERT_ON(a_div_done_in_div, div_rsp.done |-> (state_q == lbf_pkg::ST_DIV), "divider finished outside divide state")
  `ASSERT_ON(a_div_busy_in_div, div_rsp.busy |-> (state_q == lbf_pkg::ST_DIV), "divider busy outside divide state")
  `ASSERT_ON(a_wb_in_range, (state_q == lbf_pkg::ST_WB) |-> (div_rsp.quotient <= span), "interpolated step exceeds fade span")
  `ASSERT_ON(a_active_in_seq, (state_q != lbf_pkg::ST_IDLE) |-> active_q, "tick sequence running without an active fade")
  `ASSERT_ON(a_fade_end_by_tick, $fell(active_q) |-> $past(accept && (action == lbf_pkg::ACT_TICK)), "fade stopped without a tick")

endmodule

// ===== verif/linear_brightness_fader_test.sv =====
// Self-checking testbench for linear_brightness_fader: directed, config, backpressure
// and random fade sequences, checked against an in-bench fade predictor.
// Depends on lbf_pkg, lbf_in_if, lbf_out_if and the fader RTL.
module linear_brightness_fader_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [lbf_pkg::LEVEL_W-1:0] level;
    logic                        fading;
  } fade_out_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [lbf_pkg::CFG_W-1:0] cfg_wdata_i;

  lbf_in_if  cmd_if ();
  lbf_out_if res_if ();

  linear_brightness_fader u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (cmd_if),
    .res_o       (res_if)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Tracked copy of the fader state, advanced at every accepted transfer.
  logic [lbf_pkg::LEVEL_W-1:0] trk_start_lvl;
  logic [lbf_pkg::LEVEL_W-1:0] trk_target_lvl;
  logic [lbf_pkg::TIME_W-1:0]  trk_t0;
  logic [lbf_pkg::TIME_W-1:0]  trk_len;
  logic                        trk_active;
  logic [lbf_pkg::LEVEL_W-1:0] trk_level;
  logic [lbf_pkg::CFG_W-1:0]   trk_cancel_ms;

  fade_out_t pending_outputs[$];

  // Run control shared between the stimulus and the result-side driver.
  bit idle_en;
  int hold_left;
  int stall_left;

  // Bookkeeping
  int errors;
  int n_issued;
  int n_checked;
  int n_mid_ticks;
  int n_by_act[4];

  // Level update for one command. Mid-fade ticks use the full 40-bit product,
  // so a long fade with a large span never wraps.
  function automatic fade_out_t apply_fade_cmd(lbf_pkg::action_e act,
                                               logic [lbf_pkg::TIME_W-1:0] now,
                                               logic [lbf_pkg::LEVEL_W-1:0] from_lvl,
                                               logic [lbf_pkg::LEVEL_W-1:0] to_lvl,
                                               logic [lbf_pkg::TIME_W-1:0] dur);
    logic [lbf_pkg::TIME_W-1:0]  elapsed;
    logic [lbf_pkg::LEVEL_W-1:0] span;
    logic [lbf_pkg::PROD_W-1:0]  product;
    logic [lbf_pkg::PROD_W-1:0]  step;
    fade_out_t                   r;
    case (act)
      lbf_pkg::ACT_TICK: begin
        if (trk_active) begin
          elapsed = now - trk_t0;          // modular, so a wrapped clock still works
          if (elapsed >= trk_len) begin
            trk_level  = trk_target_lvl;
            trk_active = 1'b0;
          end else begin
            n_mid_ticks++;
            span    = (trk_target_lvl >= trk_start_lvl) ? trk_target_lvl - trk_start_lvl
                                                         : trk_start_lvl - trk_target_lvl;
            product = span * elapsed;
            step    = product / trk_len;   // < span, fits in 8 bits
            trk_level = (trk_target_lvl >= trk_start_lvl) ? trk_start_lvl + step[7:0]
                                                           : trk_start_lvl - step[7:0];
          end
        end
      end
      lbf_pkg::ACT_START: begin
        trk_start_lvl  = from_lvl;
        trk_target_lvl = to_lvl;
        trk_t0         = now;
        trk_len        = dur;
        trk_active     = 1'b1;
        trk_level      = from_lvl;
      end
      lbf_pkg::ACT_CANCEL: begin
        // fade from whatever is driven now, over the configured time
        trk_start_lvl  = trk_level;
        trk_target_lvl = to_lvl;
        trk_t0         = now;
        trk_len        = {{(lbf_pkg::TIME_W-lbf_pkg::CFG_W){1'b0}}, trk_cancel_ms};
        trk_active     = 1'b1;
      end
      default: trk_level = from_lvl;       // set level: a running fade keeps going
    endcase
    r.level  = trk_level;
    r.fading = trk_active;
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned exp_v, int unsigned got_v);
    errors++;
    if (errors <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, exp_v, got_v);
  endtask

  // Input monitor first, then the result check, so an expectation is queued
  // before any result for it can show up.
  always @(posedge clk_i) begin
    fade_out_t exp_out;
    if (rst_ni) begin
      if (cmd_if.valid && cmd_if.ready) begin
        n_by_act[cmd_if.action]++;
        pending_outputs.push_back(apply_fade_cmd(lbf_pkg::action_e'(cmd_if.action),
                                                 cmd_if.now_ms, cmd_if.from_level,
                                                 cmd_if.to_level, cmd_if.duration_ms));
      end
      if (res_if.valid && res_if.ready) begin
        n_checked++;
        if (pending_outputs.size() == 0) begin
          report_mismatch("unexpected result, pending count", 0, 1);
        end else begin
          exp_out = pending_outputs.pop_front();
          if (res_if.level !== exp_out.level)
            report_mismatch("level", exp_out.level, res_if.level);
          if (res_if.fading !== exp_out.fading)
            report_mismatch("fading", exp_out.fading, res_if.fading);
        end
      end
    end
  end

  // Result side: long hold-offs on request, random stall bursts when idling is on.
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 7);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // One command transfer. valid stays high across back-to-back transfers and
  // only drops for an idle burst or a quiesce.
  task automatic send_cmd(lbf_pkg::action_e act, logic [lbf_pkg::TIME_W-1:0] now,
                          logic [lbf_pkg::LEVEL_W-1:0] from_lvl,
                          logic [lbf_pkg::LEVEL_W-1:0] to_lvl,
                          logic [lbf_pkg::TIME_W-1:0] dur);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.action      <= act;
    cmd_if.now_ms      <= now;
    cmd_if.from_level  <= from_lvl;
    cmd_if.to_level    <= to_lvl;
    cmd_if.duration_ms <= dur;
    do @(posedge clk_i); while (!cmd_if.ready);
    n_issued++;
  endtask

  // Fields an action ignores get random values.
  task automatic tick_at(logic [lbf_pkg::TIME_W-1:0] now);
    send_cmd(lbf_pkg::ACT_TICK, now, lbf_pkg::LEVEL_W'($urandom),
             lbf_pkg::LEVEL_W'($urandom), $urandom);
  endtask

  task automatic start_at(logic [lbf_pkg::TIME_W-1:0] now,
                          logic [lbf_pkg::LEVEL_W-1:0] from_lvl,
                          logic [lbf_pkg::LEVEL_W-1:0] to_lvl,
                          logic [lbf_pkg::TIME_W-1:0] dur);
    send_cmd(lbf_pkg::ACT_START, now, from_lvl, to_lvl, dur);
  endtask

  task automatic cancel_at(logic [lbf_pkg::TIME_W-1:0] now,
                           logic [lbf_pkg::LEVEL_W-1:0] to_lvl);
    send_cmd(lbf_pkg::ACT_CANCEL, now, lbf_pkg::LEVEL_W'($urandom), to_lvl, $urandom);
  endtask

  task automatic set_level(logic [lbf_pkg::LEVEL_W-1:0] lvl);
    send_cmd(lbf_pkg::ACT_SET, $urandom, lvl, lbf_pkg::LEVEL_W'($urandom), $urandom);
  endtask

  // Stop offering, wait for every result, then let the divider loop settle.
  task automatic quiesce();
    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_cancel_ms(logic [lbf_pkg::CFG_W-1:0] value);
    quiesce();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    trk_cancel_ms  = value;
  endtask

  function automatic logic [lbf_pkg::LEVEL_W-1:0] rand_level();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return lbf_pkg::LEVEL_W'($urandom);
    endcase
  endfunction

  // Mostly short fades; a few span the whole 32-bit range.
  function automatic logic [lbf_pkg::TIME_W-1:0] rand_dur();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return $urandom_range(1, 4);
      2, 3, 4: return $urandom_range(5, 2000);
      5:       return $urandom_range(2001, 1 << 20);
      6:       return $urandom;
      7:       return '1;
      default: return $urandom_range(10, 300);
    endcase
  endfunction

  // Elapsed time for a tick: mostly inside the fade, sometimes at or past its end.
  function automatic logic [lbf_pkg::TIME_W-1:0] rand_elapsed(logic [lbf_pkg::TIME_W-1:0] dur);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return dur;
      2:       return dur + $urandom_range(1, 100);
      3:       return $urandom;
      default: return (dur == 0) ? '0 : $urandom_range(0, dur - 1);
    endcase
  endfunction

  // Random fade sequences: a start or cancel followed by a handful of ticks,
  // with sets, restarts and stray commands mixed in.
  task automatic random_fades(int n_items);
    int                         stop_at;
    logic [lbf_pkg::TIME_W-1:0] t0;
    logic [lbf_pkg::TIME_W-1:0] dur;
    stop_at = n_issued + n_items;
    while (n_issued < stop_at) begin
      t0 = $urandom;
      case ($urandom_range(0, 9))
        0: begin
          dur = rand_dur();
          send_cmd(lbf_pkg::action_e'($urandom_range(0, 3)), $urandom,
                   lbf_pkg::LEVEL_W'($urandom), lbf_pkg::LEVEL_W'($urandom), $urandom);
        end
        1, 2: begin
          dur = {{(lbf_pkg::TIME_W-lbf_pkg::CFG_W){1'b0}}, trk_cancel_ms};
          cancel_at(t0, rand_level());
        end
        default: begin
          dur = rand_dur();
          start_at(t0, rand_level(), rand_level(), dur);
        end
      endcase
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 19))
          0:       set_level(rand_level());
          1:       tick_at($urandom);
          2:       cancel_at(t0 + rand_elapsed(dur), rand_level());
          default: tick_at(t0 + rand_elapsed(dur));
        endcase
      end
    end
  endtask

  // Hand-picked cases with known results.
  task automatic test_directed();
    tick_at(32'd0);                       // idle tick straight out of reset: 128, not fading
    cancel_at(32'd1000, 8'd255);          // cancel from idle, 300 ms default
    tick_at(32'd1150);
    tick_at(32'd1300);
    set_level(8'd0);
    set_level(8'd255);
    start_at(32'd100, 8'd0, 8'd255, 32'd1000);
    tick_at(32'd100);
    tick_at(32'd600);
    tick_at(32'd1099);
    set_level(8'd7);                      // set while fading, next tick overrides
    tick_at(32'd1100);
    tick_at(32'd5000);
    start_at(32'd50, 8'd255, 8'd0, 32'd7); // fading down
    tick_at(32'd53);
    start_at(32'd9, 8'd200, 8'd10, 32'd0); // zero length ends on the next tick
    tick_at(32'd9);
    start_at(32'hFFFF_FFF0, 8'd0, 8'd255, 32'h40); // clock wraps mid-fade
    tick_at(32'h0000_0010);
    start_at(32'd0, 8'd10, 8'd20, 32'd100);
    cancel_at(32'd50, 8'd0);              // cancel replaces a running fade
    start_at(32'h8000_0000, 8'd255, 8'd0, 32'hFFFF_FFFF); // widest product
    tick_at(32'h7FFF_FFFE);
    tick_at(32'h7FFF_FFFF);
    start_at(32'd1000, 8'd0, 8'd255, 32'd100);
    tick_at(32'd999);                     // time behind the start: elapsed is huge
    start_at(32'd5, 8'd77, 8'd77, 32'd50);
    tick_at(32'd30);
    quiesce();
  endtask

  // cancel_fade_ms at its extremes and in between, then back to the reset value.
  task automatic test_cancel_length();
    logic [lbf_pkg::CFG_W-1:0]  settings[5];
    logic [lbf_pkg::TIME_W-1:0] t0;
    settings = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom), lbf_pkg::CANCEL_RESET_MS};
    foreach (settings[i]) begin
      write_cancel_ms(settings[i]);
      t0 = $urandom;
      set_level(rand_level());
      cancel_at(t0, rand_level());
      tick_at(t0 + settings[i] / 2);
      tick_at(t0 + settings[i]);
    end
    quiesce();
  endtask

  // Result side held off for a long stretch while commands keep coming, so the
  // output register fills and input ready drops.
  task automatic test_backpressure();
    hold_left = 200;
    random_fades(30);
    quiesce();
  endtask

  // Bulk random traffic, with a cancel_fade_ms change between chunks.
  task automatic test_random();
    for (int chunk = 0; chunk < 5; chunk++) begin
      idle_en = (chunk != 2);             // one chunk runs without idling
      case (chunk)
        0:       write_cancel_ms(16'd40);
        1:       write_cancel_ms(16'hFFFF);
        2:       write_cancel_ms(16'd0);
        3:       write_cancel_ms(16'($urandom));
        default: write_cancel_ms(lbf_pkg::CANCEL_RESET_MS);
      endcase
      random_fades(110);
    end
    quiesce();
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_full_rate();
    idle_en = 1'b0;
    random_fades(60);
    quiesce();
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    cmd_if.valid       = 1'b0;
    cmd_if.action      = lbf_pkg::ACT_TICK;
    cmd_if.now_ms      = '0;
    cmd_if.from_level  = '0;
    cmd_if.to_level    = '0;
    cmd_if.duration_ms = '0;
    idle_en            = 1'b1;
    hold_left          = 0;
    stall_left         = 0;
    trk_start_lvl      = '0;
    trk_target_lvl     = lbf_pkg::TARGET_RESET_LEVEL;
    trk_t0             = '0;
    trk_len            = '0;
    trk_active         = 1'b0;
    trk_level          = lbf_pkg::DEFAULT_LEVEL;
    trk_cancel_ms      = lbf_pkg::CANCEL_RESET_MS;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_cancel_length();
    test_backpressure();
    test_random();
    test_full_rate();

    if (pending_outputs.size() != 0)
      report_mismatch("leftover expectations", 0, pending_outputs.size());
    $display("Ran %0d commands (tick %0d, start %0d, cancel %0d, set %0d), %0d results checked.",
             n_issued, n_by_act[lbf_pkg::ACT_TICK], n_by_act[lbf_pkg::ACT_START],
             n_by_act[lbf_pkg::ACT_CANCEL], n_by_act[lbf_pkg::ACT_SET], n_checked);
    $display("%0d ticks landed inside a fade; %0d mismatches seen.", n_mid_ticks, errors);
    if (errors == 0)
      $display("linear_brightness_fader_test passed");
    else
      $display("linear_brightness_fader_test failed");
    $finish;
  end

  // Watchdog: ends the run as failed if it has not finished by then.
  initial begin
    #5ms;
    $display("linear_brightness_fader_test failed");
    $finish;
  end

endmodule
